@@ hw/rtl/tga_image_stream_decoder_assert.svh @@
// assertion helpers shared by the decoder modules
`ifndef TGA_IMAGE_STREAM_DECODER_ASSERT_SVH
`define TGA_IMAGE_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// property checked every clock edge outside reset
`define TGAD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequence checked after the antecedent, as a non-overlapping implication
`define TGAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TGAD_ASSERT(lbl, clk, rstn, prop, msg)
`define TGAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hw/rtl/tgad_pkg.sv @@
package tgad_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_SIZE      = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_CLIPPED   = 3'd4
    } err_t;

    // one colour run or error record
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        err_t        error_code;
        logic        last;
    } run_rec_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // header layout
    localparam int HDR_SIG_LEN   = 12;
    localparam int HDR_FIELD_CNT = 5;
    localparam logic [4:0] POS_SIG_LAST = 5'd11;
    localparam logic [4:0] POS_WIDTH_LO = 5'd12;
    localparam logic [4:0] POS_DESCR    = 5'd17;

    localparam logic [2:0] FLD_WIDTH_LO  = 3'd0;
    localparam logic [2:0] FLD_WIDTH_HI  = 3'd1;
    localparam logic [2:0] FLD_HEIGHT_LO = 3'd2;
    localparam logic [2:0] FLD_HEIGHT_HI = 3'd3;
    localparam logic [2:0] FLD_DEPTH     = 3'd4;

    localparam logic [7:0] SIG_RAW [HDR_SIG_LEN] = '{
        8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };
    localparam logic [7:0] SIG_RLE [HDR_SIG_LEN] = '{
        8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // pixel byte counter value on the final byte of a pixel
    localparam logic [1:0] BIP_LAST_3 = 2'd2;
    localparam logic [1:0] BIP_LAST_4 = 2'd3;

endpackage

@@ hw/rtl/tgad_front.sv @@
`include "tga_image_stream_decoder_assert.svh"

module tgad_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 beat,
    input  logic [7:0]           data_byte,
    input  logic                 file_end,
    output logic                 push,
    output tgad_pkg::run_rec_t   rec
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RAWPIX,
        PH_PKTHDR,
        PH_PKTDATA,
        PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_pos_reg, hdr_pos_next;
    logic        raw_match_reg, raw_match_next;
    logic        rle_match_reg, rle_match_next;
    logic        run_coded_reg, run_coded_next;
    logic        four_byte_reg, four_byte_next;
    logic [31:0] pix_rem_reg, pix_rem_next;
    logic [7:0]  pkt_rem_reg, pkt_rem_next;
    logic        pkt_is_run_reg, pkt_is_run_next;
    logic [1:0]  bip_reg, bip_next;

    logic [7:0]  hdr_fields_reg [tgad_pkg::HDR_FIELD_CNT];
    logic [7:0]  hdr_fields_next [tgad_pkg::HDR_FIELD_CNT];
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];

    logic [15:0] hdr_w, hdr_h;
    logic [7:0]  hdr_depth;
    logic [4:0]  pos, fld_off;
    logic        raw_m, rle_m;
    logic        pix_done;
    logic [31:0] pix_dec, pix_new;
    logic [7:0]  pkt_new, rep;
    logic        clip, is_last;
    logic        restart, to_drain, fail_trunc;

    assign hdr_w     = {hdr_fields_reg[tgad_pkg::FLD_WIDTH_HI],
                        hdr_fields_reg[tgad_pkg::FLD_WIDTH_LO]};
    assign hdr_h     = {hdr_fields_reg[tgad_pkg::FLD_HEIGHT_HI],
                        hdr_fields_reg[tgad_pkg::FLD_HEIGHT_LO]};
    assign hdr_depth = hdr_fields_reg[tgad_pkg::FLD_DEPTH];

    always_comb begin
        phase_next      = phase_reg;
        hdr_pos_next    = hdr_pos_reg;
        raw_match_next  = raw_match_reg;
        rle_match_next  = rle_match_reg;
        run_coded_next  = run_coded_reg;
        four_byte_next  = four_byte_reg;
        pix_rem_next    = pix_rem_reg;
        pkt_rem_next    = pkt_rem_reg;
        pkt_is_run_next = pkt_is_run_reg;
        bip_next        = bip_reg;
        hdr_fields_next = hdr_fields_reg;
        held_next       = held_reg;

        push       = 1'b0;
        restart    = 1'b0;
        to_drain   = 1'b0;
        fail_trunc = 1'b0;

        rec              = '0;
        rec.error_code   = tgad_pkg::ERR_NONE;
        rec.image_width  = hdr_w;
        rec.image_height = hdr_h;
        rec.has_alpha    = four_byte_reg;

        pos     = (hdr_pos_reg > tgad_pkg::POS_DESCR) ? tgad_pkg::POS_DESCR : hdr_pos_reg;
        fld_off = pos - tgad_pkg::POS_WIDTH_LO;
        raw_m   = raw_match_reg;
        rle_m   = rle_match_reg;

        // pixel assembly, shared by raw and packet data
        pix_done = (bip_reg == (four_byte_reg ? tgad_pkg::BIP_LAST_4 : tgad_pkg::BIP_LAST_3));
        pix_dec  = (pix_rem_reg != 32'd0) ? pix_rem_reg - 32'd1 : pix_rem_reg;
        pix_new  = pix_dec;
        pkt_new  = pkt_rem_reg;
        rep      = 8'd1;
        clip     = 1'b0;
        is_last  = 1'b0;

        if (beat) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (pos < tgad_pkg::POS_WIDTH_LO) begin
                        raw_m = raw_match_reg && (data_byte == tgad_pkg::SIG_RAW[pos[3:0]]);
                        rle_m = rle_match_reg && (data_byte == tgad_pkg::SIG_RLE[pos[3:0]]);
                        raw_match_next = raw_m;
                        rle_match_next = rle_m;
                    end else if (pos < tgad_pkg::POS_DESCR) begin
                        hdr_fields_next[fld_off[2:0]] = data_byte;
                    end

                    priority if (pos == tgad_pkg::POS_SIG_LAST && !raw_m && !rle_m) begin
                        push             = 1'b1;
                        rec.error_code   = tgad_pkg::ERR_SIGNATURE;
                        rec.last         = 1'b1;
                        rec.image_width  = '0;
                        rec.image_height = '0;
                        rec.has_alpha    = 1'b0;
                        restart          = file_end;
                        to_drain         = !file_end;
                    end else if (pos == tgad_pkg::POS_DESCR) begin
                        if (hdr_w == 16'd0 || hdr_h == 16'd0 ||
                            (hdr_depth != tgad_pkg::DEPTH_24 &&
                             hdr_depth != tgad_pkg::DEPTH_32)) begin
                            four_byte_next = 1'b0;
                            push           = 1'b1;
                            rec.error_code = tgad_pkg::ERR_SIZE;
                            rec.last       = 1'b1;
                            rec.has_alpha  = 1'b0;
                            restart        = file_end;
                            to_drain       = !file_end;
                        end else begin
                            four_byte_next = (hdr_depth == tgad_pkg::DEPTH_32);
                            pix_rem_next   = {16'd0, hdr_w} * {16'd0, hdr_h};
                            bip_next       = 2'd0;
                            pkt_rem_next   = 8'd0;
                            phase_next     = run_coded_reg ? PH_PKTHDR : PH_RAWPIX;
                            if (file_end) begin
                                push           = 1'b1;
                                rec.error_code = tgad_pkg::ERR_TRUNCATED;
                                rec.last       = 1'b1;
                                rec.has_alpha  = (hdr_depth == tgad_pkg::DEPTH_32);
                                restart        = 1'b1;
                            end
                        end
                    end else begin
                        if (pos == tgad_pkg::POS_SIG_LAST) begin
                            run_coded_next = !raw_m;
                        end
                        hdr_pos_next = pos + 5'd1;
                        if (file_end) begin
                            push             = 1'b1;
                            rec.error_code   = tgad_pkg::ERR_TRUNCATED;
                            rec.last         = 1'b1;
                            rec.image_width  = '0;
                            rec.image_height = '0;
                            rec.has_alpha    = 1'b0;
                            restart          = 1'b1;
                        end
                    end
                end

                PH_RAWPIX, PH_PKTDATA: begin
                    if (!pix_done) begin
                        held_next[bip_reg] = data_byte;
                        bip_next           = bip_reg + 2'd1;
                        fail_trunc         = file_end;
                    end else begin
                        bip_next = 2'd0;
                        if (phase_reg == PH_PKTDATA && pkt_is_run_reg) begin
                            clip    = ({24'd0, pkt_rem_reg} > pix_rem_reg);
                            rep     = clip ? pix_rem_reg[7:0] : pkt_rem_reg;
                            pix_new = pix_rem_reg - {24'd0, rep};
                            pkt_new = 8'd0;
                        end else if (phase_reg == PH_PKTDATA) begin
                            pkt_new = (pkt_rem_reg != 8'd0) ? pkt_rem_reg - 8'd1 : pkt_rem_reg;
                            clip    = (pix_dec == 32'd0) && (pkt_new != 8'd0);
                        end
                        pix_rem_next = pix_new;
                        pkt_rem_next = pkt_new;
                        is_last      = (pix_new == 32'd0);
                        if (file_end && !is_last) begin
                            fail_trunc = 1'b1;
                        end else begin
                            push             = 1'b1;
                            rec.red          = four_byte_reg ? held_reg[2] : data_byte;
                            rec.green        = held_reg[1];
                            rec.blue         = held_reg[0];
                            rec.alpha        = four_byte_reg ? data_byte : tgad_pkg::ALPHA_OPAQUE;
                            rec.repeat_count = rep;
                            rec.error_code   = clip ? tgad_pkg::ERR_CLIPPED
                                                    : tgad_pkg::ERR_NONE;
                            rec.last         = is_last;
                            if (is_last) begin
                                restart  = file_end;
                                to_drain = !file_end;
                            end else if (pkt_new == 8'd0 && phase_reg == PH_PKTDATA) begin
                                phase_next = PH_PKTHDR;
                            end
                        end
                    end
                end

                PH_PKTHDR: begin
                    // run packets and raw packets both count low seven bits plus one
                    pkt_is_run_next = data_byte[7];
                    pkt_rem_next    = {1'b0, data_byte[6:0]} + 8'd1;
                    bip_next        = 2'd0;
                    phase_next      = PH_PKTDATA;
                    fail_trunc      = file_end;
                end

                PH_DRAIN: begin
                    restart = file_end;
                end

                default: begin
                    restart  = file_end;
                    to_drain = !file_end;
                end
            endcase

            if (fail_trunc) begin
                push           = 1'b1;
                rec            = '0;
                rec.error_code = tgad_pkg::ERR_TRUNCATED;
                rec.image_width  = hdr_w;
                rec.image_height = hdr_h;
                rec.has_alpha  = four_byte_reg;
                rec.last       = 1'b1;
                restart        = 1'b1;
            end

            if (restart) begin
                phase_next     = PH_HEADER;
                hdr_pos_next   = 5'd0;
                raw_match_next = 1'b1;
                rle_match_next = 1'b1;
            end else if (to_drain) begin
                phase_next = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_pos_reg    <= 5'd0;
            raw_match_reg  <= 1'b1;
            rle_match_reg  <= 1'b1;
            run_coded_reg  <= 1'b0;
            four_byte_reg  <= 1'b0;
            pix_rem_reg    <= 32'd0;
            pkt_rem_reg    <= 8'd0;
            pkt_is_run_reg <= 1'b0;
            bip_reg        <= 2'd0;
        end else begin
            phase_reg      <= phase_next;
            hdr_pos_reg    <= hdr_pos_next;
            raw_match_reg  <= raw_match_next;
            rle_match_reg  <= rle_match_next;
            run_coded_reg  <= run_coded_next;
            four_byte_reg  <= four_byte_next;
            pix_rem_reg    <= pix_rem_next;
            pkt_rem_reg    <= pkt_rem_next;
            pkt_is_run_reg <= pkt_is_run_next;
            bip_reg        <= bip_next;
        end
    end

    // header bytes and partial pixel, always written before use
    always_ff @(posedge aclk) begin
        hdr_fields_reg <= hdr_fields_next;
        held_reg       <= held_next;
    end

    `TGAD_ASSERT(a_err_is_last, aclk, aresetn, !push || rec.error_code == tgad_pkg::ERR_NONE || rec.last, "error record without last")
    `TGAD_ASSERT(a_pkt_nonzero, aclk, aresetn, phase_reg != PH_PKTDATA || pkt_rem_reg != 8'd0, "packet data with empty packet")
    `TGAD_ASSERT_NEXT(a_last_drains, aclk, aresetn, push && rec.last && !file_end, phase_reg == PH_DRAIN, "final record did not drain")

endmodule

@@ hw/rtl/tgad_queue.sv @@
`include "tga_image_stream_decoder_assert.svh"

module tgad_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tgad_pkg::run_rec_t  push_rec,
    input  logic                pop,
    output tgad_pkg::run_rec_t  head_rec,
    output tgad_pkg::q_status_t status
);

    tgad_pkg::run_rec_t              slot_reg [tgad_pkg::QUEUE_DEPTH];
    logic [tgad_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tgad_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tgad_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == tgad_pkg::QUEUE_CNT_W'(tgad_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_rec     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `TGAD_ASSERT(a_no_overflow, aclk, aresetn, !(push && status.full), "push into full queue")
    `TGAD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && status.empty), "pop from empty queue")

endmodule

@@ hw/rtl/tgad_back.sv @@
module tgad_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgad_pkg::q_status_t q_status,
    input  tgad_pkg::run_rec_t  head_rec,
    output logic                pop,
    input  logic                m_ready,
    output logic                m_valid,
    output tgad_pkg::run_rec_t  out_rec
);

    logic               out_valid_reg, out_valid_next;
    tgad_pkg::run_rec_t out_rec_reg;

    // load when the output slot is free or being taken this cycle
    assign pop            = !q_status.empty && (!out_valid_reg || m_ready);
    assign out_valid_next = pop || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_rec_reg <= head_rec;
        end
    end

    assign m_valid = out_valid_reg;
    assign out_rec = out_rec_reg;

endmodule

@@ hw/rtl/tga_image_stream_decoder.sv @@
// tga image stream decoder
// input channel: one file byte per beat on s_data_byte, s_file_end high on the
//   final byte of the file; s_ready stays high unless the result queue is full
// result channel: one colour run per beat in rgba order with its repeat count,
//   the header size and depth flag, a status code and m_last on the final run
//   or on any error record
// header bytes and packet headers produce no beat unless they end the file early
//   or fail a header check; a completed pixel or run produces exactly one
// path: the front writes a result into the queue on the byte that completes it,
//   then the back moves it into the output register
// throughput: one byte per cycle while s_ready is high; every byte updates only small
//   counters, and the width by height product is one 16x16 multiply taken on
//   the descriptor byte
// reset: synchronous active-low aresetn empties the queue and the output
//   register and puts the front back to expecting a header
// stall: while m_ready is low the output register holds; the two-entry queue
//   keeps taking bytes until it fills, then s_ready drops
module tga_image_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_file_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [7:0]  m_repeat_count,
    output logic [15:0] m_image_width,
    output logic [15:0] m_image_height,
    output logic        m_has_alpha,
    output logic [2:0]  m_error_code,
    output logic        m_last
);

    logic                beat;
    logic                push;
    logic                pop;
    tgad_pkg::run_rec_t  front_rec;
    tgad_pkg::run_rec_t  head_rec;
    tgad_pkg::run_rec_t  out_rec;
    tgad_pkg::q_status_t q_status;

    // take a byte whenever the queue has room for its possible result
    assign s_ready = !q_status.full;
    assign beat    = s_valid && s_ready;

    // front: header parse, pixel assembly, run bookkeeping
    tgad_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .data_byte (s_data_byte),
        .file_end  (s_file_end),
        .push      (push),
        .rec       (front_rec)
    );

    // short queue decoupling decode from the result channel
    tgad_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (front_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    // back: registered result stage
    tgad_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_rec (head_rec),
        .pop      (pop),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .out_rec  (out_rec)
    );

    assign m_red          = out_rec.red;
    assign m_green        = out_rec.green;
    assign m_blue         = out_rec.blue;
    assign m_alpha        = out_rec.alpha;
    assign m_repeat_count = out_rec.repeat_count;
    assign m_image_width  = out_rec.image_width;
    assign m_image_height = out_rec.image_height;
    assign m_has_alpha    = out_rec.has_alpha;
    assign m_error_code   = out_rec.error_code;
    assign m_last         = out_rec.last;

endmodule
